@@ rtl/cdt_pkg.sv @@
`timescale 1ns / 1ps

package cdt_pkg;

   // Fixed field widths of the two streams and the control register.
   localparam int CompWidth       = 3;
   localparam int ValueWidth      = 32;
   localparam int OrderFieldWidth = 2;
   localparam int ReqDataWidth    = 40;
   localparam int RspDataWidth    = 40;

   // Inverse step after reset: 1.0 in unsigned Q16.16.
   localparam logic [ValueWidth-1:0] InvStepReset = 32'h0001_0000;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_WRITE = 5'b00100,
      ST_MUL   = 5'b01000,
      ST_SAT   = 5'b10000
   } state_type;

endpackage

@@ rtl/cascaded_time_derivative_tracker_core.sv @@
`timescale 1ns / 1ps
// Each item starts with a read of its order-0 stored value; its order-0 result is then
// registered in the write state, and each higher order passes in turn through the
// memory write/difference, multiply and saturate states. A busy output stalls the
// write state. A new input is taken only once the highest order of the current item
// has been presented. Reset: synchronous; afterwards the store is swept to zero, one
// entry at a time, before the first input transfer is taken.

module cascaded_time_derivative_tracker_core #(
   parameter int MAX_ORDER  = 3,
   parameter int COMPONENTS = 8
) (
   input  logic        clock,
   input  logic        reset,

   // Control register: inverse time step, unsigned Q16.16.
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,

   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [2:0] component, [34:3] sample, [39:35] zero

   // Result stream, one transfer per derivative order.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [2:0] component_out, [34:3] derivative, [39:35] zero
   output logic [1:0]  rsp_tuser,   // [1:0] order
   output logic        rsp_tlast    // set on the highest order of the item
);

   // The store is addressed by {order, component}. Both parts are at least one bit
   // wide so that the address is well formed for one component or order one.
   localparam int OrdW      = $clog2(MAX_ORDER + 1);
   localparam int CompIdxW  = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
   localparam int AddrW     = OrdW + CompIdxW;
   localparam int Depth     = 1 << AddrW;
   localparam int CompW     = cdt_pkg::CompWidth;
   localparam int ValW      = cdt_pkg::ValueWidth;
   localparam int OrdFieldW = cdt_pkg::OrderFieldWidth;
   localparam int PadW      = cdt_pkg::ReqDataWidth - CompW - ValW;

   localparam logic [6:0]      CompLimit = 7'(COMPONENTS);
   localparam logic [OrdW-1:0] LastOrd   = OrdW'(MAX_ORDER);

   // Sequencer and item state.
   cdt_pkg::state_type state_ff, state_in;
   logic [AddrW-1:0]    clr_addr_ff, clr_addr_in;
   logic [OrdW-1:0]     ord_ff, ord_in;
   logic [CompIdxW-1:0] comp_ff, comp_in;
   logic [ValW-1:0]     inv_ff, inv_in;

   // Datapath: value of the current order, difference to its stored value, product.
   logic signed [ValW-1:0]   fresh_ff, fresh_in;
   logic signed [ValW:0]     diff_ff, diff_in;
   logic signed [2*ValW+1:0] prod_ff, prod_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OrdW-1:0]     rsp_ord_ff, rsp_ord_in;
   logic [CompIdxW-1:0] rsp_comp_ff, rsp_comp_in;
   logic [ValW-1:0]     rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   // Store and its ports.
   logic [ValW-1:0]  store_ff [Depth];
   logic [ValW-1:0]  rd_data_ff;
   logic             mem_we, mem_re;
   logic [AddrW-1:0] mem_waddr, mem_raddr;
   logic [ValW-1:0]  mem_wdata;

   logic [CompW-1:0] req_comp;
   logic [ValW-1:0]  req_sample;
   logic             req_fire, comp_ok, out_free;
   logic [ValW-1:0]  sat_value;

   assign req_comp   = req_tdata[CompW-1:0];
   assign req_sample = req_tdata[CompW+ValW-1:CompW];
   assign req_tready = (state_ff == cdt_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign comp_ok    = (7'(req_comp) < CompLimit);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Arithmetic shift right by 16 floors the Q34.32 product to Q16.16; anything
   // that does not fit in 32 signed bits clamps to the nearest end of the range.
   always_comb begin
      if (prod_ff[2*ValW+1] && !(&prod_ff[2*ValW+1:ValW+15])) begin
         sat_value = {1'b1, {(ValW-1){1'b0}}};
      end else if (!prod_ff[2*ValW+1] && (|prod_ff[2*ValW+1:ValW+15])) begin
         sat_value = {1'b0, {(ValW-1){1'b1}}};
      end else begin
         sat_value = prod_ff[ValW+15:16];
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      ord_in       = ord_ff;
      comp_in      = comp_ff;
      inv_in       = csr_wr_en ? csr_wr_data : inv_ff;
      fresh_in     = fresh_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ord_in   = rsp_ord_ff;
      rsp_comp_in  = rsp_comp_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = {ord_ff, comp_ff};
      mem_wdata    = fresh_ff;
      mem_re       = 1'b0;
      mem_raddr    = {ord_ff, comp_ff};

      case (state_ff)
         cdt_pkg::ST_CLEAR: begin
            // Sweep the whole store to zero, one entry per cycle.
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (&clr_addr_ff) begin
               state_in = cdt_pkg::ST_IDLE;
            end
         end
         cdt_pkg::ST_IDLE: begin
            // An out-of-range component is taken and dropped without effect.
            if (req_fire && comp_ok) begin
               comp_in   = CompIdxW'(req_comp);
               ord_in    = '0;
               fresh_in  = req_sample;
               mem_re    = 1'b1;
               mem_raddr = {{OrdW{1'b0}}, CompIdxW'(req_comp)};
               state_in  = cdt_pkg::ST_WRITE;
            end
         end
         cdt_pkg::ST_WRITE: begin
            // The stored value of this order has arrived: replace it, form the
            // difference for the next order, present the result, and fetch the
            // next order's stored value unless this is the highest order. Waits while the output is occupied.
            if (out_free) begin
               mem_we       = 1'b1;
               diff_in      = {fresh_ff[ValW-1], fresh_ff} -
                              {rd_data_ff[ValW-1], rd_data_ff};
               rsp_valid_in = 1'b1;
               rsp_ord_in   = ord_ff;
               rsp_comp_in  = comp_ff;
               rsp_data_in  = fresh_ff;
               rsp_last_in  = (ord_ff == LastOrd);
               if (ord_ff == LastOrd) begin
                  state_in = cdt_pkg::ST_IDLE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = {ord_ff + 1'b1, comp_ff};
                  state_in  = cdt_pkg::ST_MUL;
               end
            end
         end
         cdt_pkg::ST_MUL: begin
            prod_in  = $signed({{(ValW+1){diff_ff[ValW]}}, diff_ff}) *
                       $signed({{(ValW+2){1'b0}}, inv_ff});
            state_in = cdt_pkg::ST_SAT;
         end
         cdt_pkg::ST_SAT: begin
            fresh_in = sat_value;
            ord_in   = ord_ff + 1'b1;
            state_in = cdt_pkg::ST_WRITE;
         end
         default: begin
            state_in = cdt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdt_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         inv_ff       <= cdt_pkg::InvStepReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         inv_ff       <= inv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ord_ff      <= ord_in;
      comp_ff     <= comp_in;
      fresh_ff    <= fresh_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      rsp_ord_ff  <= rsp_ord_in;
      rsp_comp_ff <= rsp_comp_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Derivative store: one write and one registered read per cycle. A read and a
   // write in the same cycle always address different orders.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_ff[mem_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PadW{1'b0}}, rsp_data_ff, CompW'(rsp_comp_ff)};
   assign rsp_tuser  = OrdFieldW'(rsp_ord_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ tb/derivative_checker.sv @@
`timescale 1ns / 1ps

module derivative_checker #(
   parameter int MaxOrder = 3,
   parameter int Channels = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [cdt_pkg::ValueWidth-1:0]   csr_wr_data,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [cdt_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [cdt_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic [1:0]                       rsp_tuser,
   input  logic                             rsp_tlast,
   output int                               failures,
   output int                               outstanding
);

   localparam int CompW = cdt_pkg::CompWidth;
   localparam int ValW  = cdt_pkg::ValueWidth;
   localparam int OrdW  = cdt_pkg::OrderFieldWidth;

   typedef struct packed {
      logic [OrdW-1:0]  order;
      logic [CompW-1:0] comp;
      logic [ValW-1:0]  value;
      logic             last;
   } order_result_type;

   order_result_type expected_orders[$];
   logic [ValW-1:0]  history [0:MaxOrder][0:Channels-1];
   logic [ValW-1:0]  inv_step;

   // Floor of (newer - older) * step / 2^16, clamped to the signed 32-bit range.
   function automatic logic [ValW-1:0] scaled_difference(
      input logic [ValW-1:0] newer,
      input logic [ValW-1:0] older,
      input logic [ValW-1:0] step
   );
      logic signed [65:0] diff;
      logic signed [65:0] prod;
      diff = $signed({{34{newer[31]}}, newer}) - $signed({{34{older[31]}}, older});
      prod = diff * $signed({34'b0, step});
      prod = prod >>> 16;
      if (prod > 66'sd2147483647) return 32'h7FFF_FFFF;
      if (prod < -66'sd2147483648) return 32'h8000_0000;
      return prod[31:0];
   endfunction

   task automatic track_sample(input logic [CompW-1:0] comp,
                               input logic [ValW-1:0] sample);
      logic [ValW-1:0]  fresh;
      logic [ValW-1:0]  prior;
      logic [ValW-1:0]  rate;
      order_result_type r;
      fresh = sample;
      prior = history[0][comp];
      history[0][comp] = sample;
      for (int n = 0; n <= MaxOrder; n++) begin
         if (n > 0) begin
            rate = scaled_difference(fresh, prior, inv_step);
            prior = history[n][comp];
            history[n][comp] = rate;
            fresh = rate;
         end
         r.order = OrdW'(n);
         r.comp  = comp;
         r.value = fresh;
         r.last  = (n == MaxOrder);
         expected_orders = {expected_orders, r};
      end
   endtask

   task automatic flag(input string what, input logic [ValW-1:0] want,
                       input logic [ValW-1:0] got);
      failures++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
   endtask

   task automatic check_result(input order_result_type got);
      order_result_type want;
      if (expected_orders.size() == 0) begin
         failures++;
         $display("%0t: unexpected result: expected none, got order %0d comp %0d value %h",
                  $time, got.order, got.comp, got.value);
         return;
      end
      want = expected_orders.pop_front();
      if (got.order != want.order) flag("order", ValW'(want.order), ValW'(got.order));
      if (got.comp != want.comp)   flag("component", ValW'(want.comp), ValW'(got.comp));
      if (got.value != want.value) flag("derivative", want.value, got.value);
      if (got.last != want.last)   flag("last", ValW'(want.last), ValW'(got.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n <= MaxOrder; n++)
            for (int c = 0; c < Channels; c++)
               history[n][c] = '0;
         inv_step = cdt_pkg::InvStepReset;
         expected_orders.delete();
         failures = 0;
      end else begin
         if (csr_wr_en) inv_step = csr_wr_data;
         // Results belong to older items, so they are checked before a new one is queued.
         if (rsp_tvalid && rsp_tready)
            check_result('{rsp_tuser, rsp_tdata[CompW-1:0],
                           rsp_tdata[CompW+ValW-1:CompW], rsp_tlast});
         if (req_tvalid && req_tready)
            track_sample(req_tdata[CompW-1:0], req_tdata[CompW+ValW-1:CompW]);
      end
      outstanding <= expected_orders.size();
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   // The run is stopped here at the latest; a correct run needs a small fraction of this.
   localparam int CycleLimit = 200000;
   // Cycles allowed for the block to settle back to idle once all results have arrived.
   localparam int Settle     = 12;

   logic                             clock;
   logic                             reset       = 1'b1;
   logic                             csr_wr_en   = 1'b0;
   logic [cdt_pkg::ValueWidth-1:0]   csr_wr_data = '0;
   logic                             req_tvalid  = 1'b0;
   logic                             req_tready;
   logic [cdt_pkg::ReqDataWidth-1:0] req_tdata   = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready  = 1'b0;
   logic [cdt_pkg::RspDataWidth-1:0] rsp_tdata;
   logic [1:0]                       rsp_tuser;
   logic                             rsp_tlast;

   int                               failures;
   int                               outstanding;
   int                               cycle_count = 0;
   logic [cdt_pkg::ValueWidth-1:0]   last_sample [0:7];
   bit                               sender_calm   = 1'b0;
   bit                               receiver_calm = 1'b0;

   cascaded_time_derivative_tracker_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // The checker sits beside the block, predicting every result and counting failures.
   derivative_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A hung block is caught here rather than left to run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offers one sample after a random gap and returns in the time step of its transfer.
   // The valid line is only lowered when a gap follows, so that back-to-back transfers
   // never see a low and a high assigned in the same step.
   task automatic send_sample(input logic [cdt_pkg::CompWidth-1:0] comp,
                              input logic [cdt_pkg::ValueWidth-1:0] sample);
      int gap;
      if ($urandom_range(0, 15) == 0) sender_calm = ~sender_calm;
      gap = sender_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, sample, comp};
      last_sample[comp] = sample;
      do @(posedge clock); while (!req_tready);
   endtask

   // Holds the sender back until every predicted result has been seen, then lets the
   // block finish any remaining internal work.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   task automatic write_step(input logic [cdt_pkg::ValueWidth-1:0] step);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= step;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly slowly moving signals, so that the higher orders carry meaningful values
   // rather than saturating, mixed with wild jumps, extremes and repeated samples.
   function automatic logic [cdt_pkg::ValueWidth-1:0] next_sample(
      input logic [cdt_pkg::CompWidth-1:0] comp
   );
      logic [cdt_pkg::ValueWidth-1:0] s;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: s = last_sample[comp] + $urandom_range(0, 32'h0002_0000)
                               - 32'h0001_0000;
         6, 7: s = $urandom;
         8: begin
            case ($urandom_range(0, 3))
               0: s = 32'h7FFF_FFFF;
               1: s = 32'h8000_0000;
               2: s = 32'h0000_0000;
               default: s = 32'hFFFF_FFFF;
            endcase
         end
         default: s = last_sample[comp];
      endcase
      return s;
   endfunction

   // The receiver draws a stall for every result, with occasional stretches of none.
   initial begin
      int stall;
      forever begin
         if ($urandom_range(0, 15) == 0) receiver_calm = ~receiver_calm;
         stall = receiver_calm ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      logic [cdt_pkg::CompWidth-1:0]  comp;
      logic [cdt_pkg::ValueWidth-1:0] step;
      for (int c = 0; c < 8; c++) last_sample[c] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Unity step from reset: full-scale swings saturate both ways, small ramps give
      // exact first and second derivatives, and a repeated sample gives a zero difference.
      send_sample(3'd0, 32'h7FFF_FFFF);
      send_sample(3'd0, 32'h8000_0000);
      send_sample(3'd0, 32'h7FFF_FFFF);
      send_sample(3'd7, 32'hFFFF_FFFF);
      send_sample(3'd7, 32'h0000_0000);
      send_sample(3'd7, 32'h0000_0001);
      send_sample(3'd3, 32'h0001_0000);
      send_sample(3'd3, 32'h0002_0000);
      send_sample(3'd3, 32'h0004_0000);
      send_sample(3'd3, 32'h0004_0000);
      send_sample(3'd5, 32'hFFFF_0000);
      send_sample(3'd6, 32'h5555_5555);
      send_sample(3'd1, 32'hAAAA_AAAA);

      // A zero step must force every derivative to zero while order 0 still follows.
      drain();
      write_step(32'h0000_0000);
      send_sample(3'd2, 32'h1234_5678);
      send_sample(3'd2, 32'h7FFF_FFFF);
      send_sample(3'd0, 32'h8000_0000);

      // The largest step scales a one-LSB change to just under 1.0 and saturates large differences.
      drain();
      write_step(32'hFFFF_FFFF);
      send_sample(3'd4, 32'h0000_0001);
      send_sample(3'd4, 32'hFFFF_FFFF);
      send_sample(3'd4, 32'h7FFF_FFFF);

      // The smallest non-zero step shrinks differences, with floor rounding on negatives.
      drain();
      write_step(32'h0000_0001);
      send_sample(3'd1, 32'h7FFF_FFFF);
      send_sample(3'd1, 32'h8000_0000);

      // Random phases, each under its own step setting.
      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: step = 32'h0001_0000;
            1: step = $urandom_range(1, 32'h0004_0000);
            2: step = $urandom;
            3: step = 32'hFFFF_FFFF;
            default: step = 32'h0000_0000;
         endcase
         write_step(step);
         for (int i = 0; i < 18; i++) begin
            // One extra full stop in the middle of a phase, with no register change.
            if (phase == 2 && i == 9) drain();
            comp = $urandom_range(0, 7);
            send_sample(comp, next_sample(comp));
         end
      end

      drain();
      if (failures == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
